@@ design/pow2_segregated_block_allocator_core_macros.svh @@
// Assertion macros used by the checker file.
`ifndef POW2_SEGREGATED_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define POW2_SEGREGATED_BLOCK_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define P2SBA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("p2sba assertion failed");

// Next-cycle implication, disabled during reset.
`define P2SBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("p2sba assertion failed");

`endif

@@ design/p2sba_pkg.sv @@
`default_nettype none
package p2sba_pkg;

	localparam int POOL_ADDR_BITS   = 25;
	localparam int MIN_CLASS        = 5;
	localparam int NUM_CLASSES      = 21;
	localparam int BLOCKS_PER_CLASS = 10;

	localparam int ACT_W  = 2;
	localparam int REQ_W  = 21;
	localparam int ADDR_W = 25;
	localparam int ST_W   = 2;
	localparam int CLS_W  = 5;
	localparam int POOL_W = 26;

	localparam int SLOT_BITS  = POOL_ADDR_BITS - MIN_CLASS;
	localparam int SLOT_COUNT = 1 << SLOT_BITS;
	localparam int HIDX_W     = $clog2(NUM_CLASSES);
	localparam int CNT_W      = $clog2(NUM_CLASSES + 1);
	localparam int K_W        = $clog2(BLOCKS_PER_CLASS + 1);
	localparam int RC_W       = $clog2(REQ_W + 1);
	localparam int MAX_AN     = (POOL_ADDR_BITS > NUM_CLASSES) ? POOL_ADDR_BITS : NUM_CLASSES;
	localparam int SUM_W      = ((MAX_AN > POOL_W) ? MAX_AN : POOL_W) + 2;

	localparam logic [ACT_W-1:0] ACT_INIT  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd1;
	localparam logic [ACT_W-1:0] ACT_FREE  = 2'd2;

	localparam logic [ST_W-1:0] ST_OK     = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE  = 2'd1;
	localparam logic [ST_W-1:0] ST_NOFREE = 2'd2;
	localparam logic [ST_W-1:0] ST_FREED  = 2'd3;

	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] CMD_NONE        = 4'd0;
	localparam logic [OP_W-1:0] CMD_START_INIT  = 4'd1;
	localparam logic [OP_W-1:0] CMD_START_ALLOC = 4'd2;
	localparam logic [OP_W-1:0] CMD_START_FREE  = 4'd3;
	localparam logic [OP_W-1:0] CMD_INIT_PUSH   = 4'd4;
	localparam logic [OP_W-1:0] CMD_FIND        = 4'd5;
	localparam logic [OP_W-1:0] CMD_POP_RD      = 4'd6;
	localparam logic [OP_W-1:0] CMD_POP_UPD     = 4'd7;
	localparam logic [OP_W-1:0] CMD_SPLIT       = 4'd8;
	localparam logic [OP_W-1:0] CMD_FINAL       = 4'd9;
	localparam logic [OP_W-1:0] CMD_FREE_RD     = 4'd10;
	localparam logic [OP_W-1:0] CMD_FREE_PUSH   = 4'd11;
	localparam logic [OP_W-1:0] CMD_LOAD        = 4'd12;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [ST_W-1:0] st;
		logic            grant;
	} cmd_t;

	typedef struct packed {
		logic init_done;
		logic class_bad;
		logic none_free;
		logic split_done;
		logic cls_ok;
	} sts_t;

endpackage
`default_nettype wire

@@ design/p2sba_if.sv @@
`default_nettype none
interface p2sba_req_if;
	import p2sba_pkg::*;
	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [REQ_W-1:0]  request_bytes;
	logic [ADDR_W-1:0] block_address;
	modport source (output valid, action, request_bytes, block_address, input ready);
	modport sink (input valid, action, request_bytes, block_address, output ready);
endinterface

interface p2sba_rsp_if;
	import p2sba_pkg::*;
	logic              valid;
	logic              ready;
	logic [ST_W-1:0]   status;
	logic [ADDR_W-1:0] granted_address;
	logic [CLS_W-1:0]  granted_class;
	modport source (output valid, status, granted_address, granted_class, input ready);
	modport sink (input valid, status, granted_address, granted_class, output ready);
endinterface

interface p2sba_cfg_if;
	import p2sba_pkg::*;
	logic              valid;
	logic              ready;
	logic [POOL_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

@@ design/pow2_segregated_block_allocator_core.sv @@
// Power-of-two free-list allocator: one LIFO list per block class over a pool
// of 32-byte slots, with splitting of a larger block when a class runs dry and
// no coalescing. One request word is taken at a time and produces one response
// word, held in an output register so the next request can be taken while it
// waits. Allocate pops a block from the smallest non-empty class that fits and
// halves it step by step (from a 1 MiB block down to 32 B at most); free reads
// the block's class and pushes it back; init lays out blocks class by class.
// Each list update is one read-modify-write of the single-ported link and
// class memories. No clearing pass runs after reset; issue init before use.
`default_nettype none
module pow2_segregated_block_allocator_core (
	input  wire   clk,
	input  wire   arst_n,
	p2sba_req_if.sink   req,
	p2sba_rsp_if.source rsp,
	p2sba_cfg_if.sink   cfg
);
	import p2sba_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg.ready = 1'b1;

	p2sba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_action (req.action),
		.in_ready  (req.ready),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.cmd       (cmd),
		.sts       (sts)
	);

	p2sba_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.request_bytes   (req.request_bytes),
		.block_address   (req.block_address),
		.cfg_we          (cfg.valid),
		.cfg_data        (cfg.data),
		.status          (rsp.status),
		.granted_address (rsp.granted_address),
		.granted_class   (rsp.granted_class)
	);
endmodule
`default_nettype wire

@@ design/p2sba_ctrl.sv @@
`default_nettype none
module p2sba_ctrl (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	input  wire [p2sba_pkg::ACT_W-1:0] in_action,
	output logic                    in_ready,
	input  wire                     out_ready,
	output logic                    out_valid,
	output p2sba_pkg::cmd_t         cmd,
	input  p2sba_pkg::sts_t         sts
);
	import p2sba_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_INIT     = 4'd1;
	localparam logic [3:0] S_FIND     = 4'd2;
	localparam logic [3:0] S_POPRD    = 4'd3;
	localparam logic [3:0] S_POPUPD   = 4'd4;
	localparam logic [3:0] S_SPLIT    = 4'd5;
	localparam logic [3:0] S_FREERD   = 4'd6;
	localparam logic [3:0] S_FREEPUSH = 4'd7;
	localparam logic [3:0] S_DONE     = 4'd8;

	logic [3:0]      state_q, state_d;
	logic [ST_W-1:0] res_st_q, st_d;
	logic            res_grant_q, grant_d, st_we;
	logic            out_valid_q;

	always_comb begin
		state_d   = state_q;
		cmd.op    = CMD_NONE;
		cmd.st    = res_st_q;
		cmd.grant = res_grant_q;
		in_ready  = 1'b0;
		st_we     = 1'b0;
		st_d      = ST_OK;
		grant_d   = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (in_action)
						ACT_INIT: begin
							cmd.op  = CMD_START_INIT;
							state_d = S_INIT;
						end
						ACT_ALLOC: begin
							cmd.op  = CMD_START_ALLOC;
							state_d = S_FIND;
						end
						ACT_FREE: begin
							cmd.op  = CMD_START_FREE;
							state_d = S_FREERD;
						end
						default: begin
							st_we   = 1'b1;
							st_d    = ST_RANGE;
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_INIT: begin
				if (sts.init_done) begin
					st_we   = 1'b1;
					st_d    = ST_OK;
					state_d = S_DONE;
				end else begin
					cmd.op = CMD_INIT_PUSH;
				end
			end
			S_FIND: begin
				if (sts.class_bad) begin
					st_we   = 1'b1;
					st_d    = ST_RANGE;
					state_d = S_DONE;
				end else if (sts.none_free) begin
					st_we   = 1'b1;
					st_d    = ST_NOFREE;
					state_d = S_DONE;
				end else begin
					cmd.op  = CMD_FIND;
					state_d = S_POPRD;
				end
			end
			S_POPRD: begin
				cmd.op  = CMD_POP_RD;
				state_d = S_POPUPD;
			end
			S_POPUPD: begin
				cmd.op  = CMD_POP_UPD;
				state_d = S_SPLIT;
			end
			S_SPLIT: begin
				if (sts.split_done) begin
					cmd.op  = CMD_FINAL;
					st_we   = 1'b1;
					st_d    = ST_OK;
					grant_d = 1'b1;
					state_d = S_DONE;
				end else begin
					cmd.op = CMD_SPLIT;
				end
			end
			S_FREERD: begin
				cmd.op  = CMD_FREE_RD;
				state_d = S_FREEPUSH;
			end
			S_FREEPUSH: begin
				if (sts.cls_ok) begin
					cmd.op = CMD_FREE_PUSH;
				end
				st_we   = 1'b1;
				st_d    = ST_FREED;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.op  = CMD_LOAD;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			res_st_q    <= ST_OK;
			res_grant_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (st_we) begin
				res_st_q    <= st_d;
				res_grant_q <= grant_d;
			end
			if (cmd.op == CMD_LOAD) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

@@ design/p2sba_dpath.sv @@
`default_nettype none
module p2sba_dpath (
	input  wire                          clk,
	input  wire                          arst_n,
	input  p2sba_pkg::cmd_t              cmd,
	output p2sba_pkg::sts_t              sts,
	input  wire [p2sba_pkg::REQ_W-1:0]   request_bytes,
	input  wire [p2sba_pkg::ADDR_W-1:0]  block_address,
	input  wire                          cfg_we,
	input  wire [p2sba_pkg::POOL_W-1:0]  cfg_data,
	output logic [p2sba_pkg::ST_W-1:0]   status,
	output logic [p2sba_pkg::ADDR_W-1:0] granted_address,
	output logic [p2sba_pkg::CLS_W-1:0]  granted_class
);
	import p2sba_pkg::*;

	function automatic logic [RC_W-1:0] ceil_log2(input logic [REQ_W-1:0] r);
		logic [REQ_W-1:0] m;
		logic [RC_W-1:0]  l;
		m = r - REQ_W'(1);
		l = '0;
		for (int i = 0; i < REQ_W; i++) begin
			if (m[i]) l = RC_W'(i + 1);
		end
		return l;
	endfunction

	logic [POOL_W-1:0]    pool_q;
	logic [SLOT_BITS-1:0] head_slot_q [NUM_CLASSES];
	logic [NUM_CLASSES-1:0] head_vld_q;

	logic [SLOT_BITS:0]   link_mem [SLOT_COUNT];
	logic [CLS_W-1:0]     cls_mem [SLOT_COUNT];
	logic [SLOT_BITS:0]   link_rd_q;
	logic [CLS_W-1:0]     cls_rd_q;

	logic [SUM_W-1:0]     ofs_q;
	logic [CNT_W-1:0]     icls_q;
	logic [K_W-1:0]       k_q;
	logic [HIDX_W-1:0]    c_q, j_q, j_dec, found_idx;
	logic                 bad_q, found;
	logic [SLOT_BITS-1:0] slot_q;

	logic [RC_W-1:0]      rc;
	logic                 rc_bad;
	logic [SUM_W-1:0]     size, limit, pool_ext, cap;

	logic                 push_en;
	logic [HIDX_W-1:0]    push_idx;
	logic [SLOT_BITS-1:0] push_slot;
	logic                 cls_we;
	logic [SLOT_BITS-1:0] cls_wa;
	logic [CLS_W-1:0]     cls_wd;
	logic [POOL_ADDR_BITS-1:0] addr_full;

	assign rc     = ceil_log2(request_bytes);
	assign rc_bad = (request_bytes == '0) || (int'(rc) < MIN_CLASS) || (int'(rc) >= NUM_CLASSES);

	assign size     = SUM_W'(1) << icls_q;
	assign pool_ext = SUM_W'(pool_q);
	assign cap      = SUM_W'(1) << POOL_ADDR_BITS;
	assign limit    = (pool_ext > cap) ? cap : pool_ext;
	assign j_dec    = j_q - HIDX_W'(1);

	always_comb begin
		found     = 1'b0;
		found_idx = '0;
		for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
			if (head_vld_q[i] && (HIDX_W'(i) >= c_q)) begin
				found     = 1'b1;
				found_idx = HIDX_W'(i);
			end
		end
	end

	assign sts.init_done  = (icls_q == CNT_W'(NUM_CLASSES)) || ((ofs_q + size) > limit);
	assign sts.class_bad  = bad_q;
	assign sts.none_free  = !found;
	assign sts.split_done = (j_q == c_q);
	assign sts.cls_ok     = (int'(cls_rd_q) >= MIN_CLASS) && (int'(cls_rd_q) < NUM_CLASSES);

	always_comb begin
		push_en   = 1'b0;
		push_idx  = '0;
		push_slot = '0;
		case (cmd.op)
			CMD_INIT_PUSH: begin
				push_en   = 1'b1;
				push_idx  = HIDX_W'(icls_q);
				push_slot = SLOT_BITS'(ofs_q >> MIN_CLASS);
			end
			CMD_SPLIT: begin
				push_en   = 1'b1;
				push_idx  = j_dec;
				push_slot = slot_q;
			end
			CMD_FREE_PUSH: begin
				push_en   = 1'b1;
				push_idx  = HIDX_W'(cls_rd_q);
				push_slot = slot_q;
			end
			default: begin
				push_en = 1'b0;
			end
		endcase
		cls_we = push_en || (cmd.op == CMD_FINAL);
		cls_wa = push_en ? push_slot : slot_q;
		cls_wd = push_en ? CLS_W'(push_idx) : CLS_W'(c_q);
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			link_mem[push_slot] <= {head_vld_q[push_idx], head_slot_q[push_idx]};
		end
		if (cmd.op == CMD_POP_RD) begin
			link_rd_q <= link_mem[slot_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cls_we) begin
			cls_mem[cls_wa] <= cls_wd;
		end
		if (cmd.op == CMD_FREE_RD) begin
			cls_rd_q <= cls_mem[slot_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= '0;
			pool_q     <= POOL_W'(33554432);
		end else begin
			if (cfg_we) begin
				pool_q <= cfg_data;
			end
			if (cmd.op == CMD_START_INIT) begin
				head_vld_q <= '0;
			end
			if (push_en) begin
				head_vld_q[push_idx] <= 1'b1;
			end
			if (cmd.op == CMD_POP_UPD) begin
				head_vld_q[j_q] <= link_rd_q[SLOT_BITS];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			head_slot_q[push_idx] <= push_slot;
		end
		if (cmd.op == CMD_POP_UPD) begin
			head_slot_q[j_q] <= link_rd_q[SLOT_BITS-1:0];
		end
	end

	assign addr_full = {slot_q, {MIN_CLASS{1'b0}}};

	always_ff @(posedge clk) begin
		case (cmd.op)
			CMD_START_INIT: begin
				ofs_q  <= '0;
				icls_q <= CNT_W'(MIN_CLASS);
				k_q    <= '0;
			end
			CMD_INIT_PUSH: begin
				ofs_q <= ofs_q + size;
				if (k_q == K_W'(BLOCKS_PER_CLASS - 1)) begin
					k_q    <= '0;
					icls_q <= icls_q + CNT_W'(1);
				end else begin
					k_q <= k_q + K_W'(1);
				end
			end
			CMD_START_ALLOC: begin
				c_q   <= HIDX_W'(rc);
				bad_q <= rc_bad;
			end
			CMD_START_FREE: begin
				slot_q <= SLOT_BITS'(block_address >> MIN_CLASS);
			end
			CMD_FIND: begin
				j_q    <= found_idx;
				slot_q <= head_slot_q[found_idx];
			end
			CMD_SPLIT: begin
				j_q    <= j_dec;
				slot_q <= slot_q + (SLOT_BITS'(1) << (j_dec - HIDX_W'(MIN_CLASS)));
			end
			CMD_LOAD: begin
				status <= cmd.st;
				if (cmd.grant) begin
					granted_address <= ADDR_W'(addr_full);
					granted_class   <= CLS_W'(c_q);
				end else begin
					granted_address <= '0;
					granted_class   <= '0;
				end
			end
			default: begin
				ofs_q <= ofs_q;
			end
		endcase
	end
endmodule
`default_nettype wire

@@ design/p2sba_checker.sv @@
`default_nettype none
`include "pow2_segregated_block_allocator_core_macros.svh"
module p2sba_checker (
	input wire                         clk,
	input wire                         arst_n,
	input wire                         req_valid,
	input wire                         req_ready,
	input wire                         rsp_valid,
	input wire                         rsp_ready,
	input wire [p2sba_pkg::ST_W-1:0]   status,
	input wire [p2sba_pkg::ADDR_W-1:0] granted_address,
	input wire [p2sba_pkg::CLS_W-1:0]  granted_class
);
	import p2sba_pkg::*;

	`P2SBA_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(granted_address) && $stable(granted_class))
	`P2SBA_ASSERT_NOW(a_zero_unless_ok, clk, arst_n, rsp_valid && (status != ST_OK), (granted_address == '0) && (granted_class == '0))
	`P2SBA_ASSERT_NOW(a_grant_shape, clk, arst_n, rsp_valid && (status == ST_OK) && (granted_class != '0), (int'(granted_class) >= MIN_CLASS) && (int'(granted_class) < NUM_CLASSES) && (granted_address[MIN_CLASS-1:0] == '0))
	`P2SBA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req_valid && req_ready, !req_ready)
endmodule

bind pow2_segregated_block_allocator_core p2sba_checker u_p2sba_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.status          (rsp.status),
	.granted_address (rsp.granted_address),
	.granted_class   (rsp.granted_class)
);
`default_nettype wire
